// ===== design/hctg_pkg.sv =====
// Shared constants and types for the hop channel table generator.
`timescale 1ns / 1ps

package hctg_pkg;

	// Generator step: state * LCG_MUL + LCG_ADD, mod 2^32
	localparam logic [23:0] LCG_MUL = 24'h19660D;
	localparam logic [31:0] LCG_ADD = 32'h3C6EF35F;

	// Channel range and bands (band edges as slot numbers, channel = slot + 2)
	localparam logic [6:0] CHAN_SPAN  = 7'd73;
	localparam logic [6:0] CHAN_BASE  = 7'd2;
	localparam logic [6:0] BAND0_SLOT = 7'd24;	// channel 26
	localparam logic [6:0] BAND1_SLOT = 7'd48;	// channel 50
	localparam logic [3:0] BAND_LIMIT = 4'd8;

	// List size limits and draw cap
	localparam int MAX_LIST         = 24;
	localparam int NUM_CHANNELS_DEF = 20;
	localparam logic [16:0] MAX_DRAWS = 17'd65536;

	// Reciprocal of 73 scaled by 2^30, rounded down; quotient may come out one low
	localparam logic [23:0] RECIP_73    = 24'd14708792;
	localparam int          RECIP_SHIFT = 30;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_RECIP,
		S_BACK,
		S_SLOT,
		S_CHECK
	} seq_state_t;

	typedef enum logic [1:0] {
		BAND_LOW  = 2'd0,
		BAND_MID  = 2'd1,
		BAND_HIGH = 2'd2
	} band_t;

endpackage

// ===== design/hop_channel_table_generator.sv =====
// Top level: seeded hop channel list generator with one shared multiplier.
//
// Usage: drive seed and pulse start while busy is low; the seed is taken at
// that edge and busy rises on the next cycle. The block then draws candidate
// channels from a 32-bit congruential generator and, for each accepted one,
// shows channel, position and last on the result ports for exactly one cycle
// with valid high. last marks the item that completes the list of
// NUM_CHANNELS (clamped to 1..24) channels; busy is already low in that cycle.
// Draw sequence: every generator draw passes through S_STEP, S_RECIP, S_BACK,
// S_SLOT and S_CHECK, since the one multiplier is used three times per draw
// (generator step, reciprocal multiply for mod 73, back multiply) followed by
// a slot fix-up step and a check step. A seed that has not filled its list
// after 65536 draws ends without an item carrying last.
// Reset: arst_n clears the sequencer and the valid strobe; the channel map and
// band counters are cleared again at every accepted seed.
// Results cannot be stalled: the receiver must take each one in its cycle.
`timescale 1ns / 1ps

module hop_channel_table_generator #(
	parameter int NUM_CHANNELS = hctg_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] seed,
	output logic        valid,
	output logic [6:0]  channel,
	output logic [4:0]  position,
	output logic        last
);

	import hctg_pkg::*;

	localparam int TARGET = (NUM_CHANNELS < 1) ? 1 :
		((NUM_CHANNELS > MAX_LIST) ? MAX_LIST : NUM_CHANNELS);
	localparam logic [4:0] LAST_POS = 5'(TARGET - 1);

	seq_state_t  state_q, state_d;

	logic [31:0] gen_q;
	logic        par_q;
	logic [47:0] prod_q;
	logic [6:0]  slot_q;
	band_t       band_q;
	logic [72:0] used_q;
	logic [3:0]  band_cnt_q [3];
	logic [4:0]  fill_q;
	logic [16:0] draw_q;

	logic        valid_q;
	logic [6:0]  channel_q;
	logic [4:0]  position_q;
	logic        last_q;

	logic        take;
	logic        keep;
	logic        done;
	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic [47:0] mul_p;
	logic [23:0] rem_full;
	logic [7:0]  rem;
	logic [6:0]  slot_d;

	assign take = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);

	// Shared multiplier operand select
	always_comb begin
		case (state_q)
			S_STEP: begin
				mul_a = gen_q;
				mul_b = LCG_MUL;
			end
			S_RECIP: begin
				mul_a = {8'd0, gen_q[31:8]};
				mul_b = RECIP_73;
			end
			S_BACK: begin
				mul_a = 32'(prod_q[47:RECIP_SHIFT]);
				mul_b = 24'(CHAN_SPAN);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 48'(mul_a) * 48'(mul_b);

	// Remainder fix-up: estimate is at most one quotient short
	assign rem_full = gen_q[31:8] - prod_q[23:0];
	assign rem      = rem_full[7:0];
	assign slot_d   = (rem >= 8'(CHAN_SPAN)) ? 7'(rem - 8'(CHAN_SPAN)) : rem[6:0];

	// Candidate checks: parity, already used, band full
	assign keep = (slot_q[0] != par_q) && !used_q[slot_q]
		&& (band_cnt_q[band_q] < BAND_LIMIT);
	assign done = keep && (fill_q == LAST_POS);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_STEP;
			end
			S_STEP: begin
				if (draw_q == MAX_DRAWS) state_d = S_IDLE;
				else state_d = S_RECIP;
			end
			S_RECIP: state_d = S_BACK;
			S_BACK:  state_d = S_SLOT;
			S_SLOT:  state_d = S_CHECK;
			S_CHECK: begin
				if (done) state_d = S_IDLE;
				else state_d = S_STEP;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Control counters and per-seed tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			band_cnt_q[0] <= '0;
			band_cnt_q[1] <= '0;
			band_cnt_q[2] <= '0;
			fill_q        <= '0;
			draw_q        <= '0;
		end else if (take) begin
			used_q        <= '0;
			band_cnt_q[0] <= '0;
			band_cnt_q[1] <= '0;
			band_cnt_q[2] <= '0;
			fill_q        <= '0;
			draw_q        <= '0;
		end else if (state_q == S_STEP && draw_q != MAX_DRAWS) begin
			draw_q <= draw_q + 17'd1;
		end else if (state_q == S_CHECK && keep) begin
			used_q[slot_q]     <= 1'b1;
			band_cnt_q[band_q] <= band_cnt_q[band_q] + 4'd1;
			fill_q             <= fill_q + 5'd1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			gen_q <= seed;
			par_q <= seed[0];
		end
		case (state_q)
			S_STEP:  gen_q  <= mul_p[31:0] + LCG_ADD;
			S_RECIP: prod_q <= mul_p;
			S_BACK:  prod_q <= mul_p;
			S_SLOT: begin
				slot_q <= slot_d;
				if (slot_d <= BAND0_SLOT) band_q <= BAND_LOW;
				else if (slot_d <= BAND1_SLOT) band_q <= BAND_MID;
				else band_q <= BAND_HIGH;
			end
			default: ;
		endcase
	end

	// Result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= (state_q == S_CHECK) && keep;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK && keep) begin
			channel_q  <= slot_q + CHAN_BASE;
			position_q <= fill_q;
			last_q     <= (fill_q == LAST_POS);
		end
	end

	assign valid    = valid_q;
	assign channel  = channel_q;
	assign position = position_q;
	assign last     = last_q;

`ifndef ASSERT_OFF
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (channel >= 7'd2 && channel <= 7'd74))
		else $error("channel out of range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (position <= LAST_POS))
		else $error("position beyond list size");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |-> !busy)
		else $error("still busy after final channel");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("seed taken without going busy");
`endif

endmodule
